@@ hdl/nnl_pkg.sv @@
// Shared types and constants for the 2D nearest-neighbor lookup unit.
// No dependencies.
`default_nettype none

package nnl_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned COORD_W        = 16;
    localparam int unsigned SQ_W           = 32;
    localparam int unsigned DIST_W         = 34;
    localparam int unsigned INDEX_W        = 11;
    localparam int unsigned PADDR_W        = 4;
    localparam int unsigned PDATA_W        = 64;
    localparam logic [DIST_W-1:0] DIST_LIMIT_RESET = 34'd6553600000;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [0:0] {
        REG_DIST_LIMIT = 1'b0
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic start_query;
        logic issue;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic pipe_busy;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/nnl_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on nnl_pkg.
`default_nettype none

module nnl_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [nnl_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [nnl_pkg::PDATA_W-1:0]        pwdata,
    output logic      [nnl_pkg::PDATA_W-1:0]        prdata,
    output logic                                    pready,
    output logic      [nnl_pkg::DIST_W-1:0]         dist_limit_sq
);

    logic [nnl_pkg::DIST_W-1:0] limit_reg;
    logic [nnl_pkg::DIST_W-1:0] limit_next;
    logic                       hit_limit;

    // 8-byte register slots, index is paddr[3]
    assign hit_limit = (paddr[nnl_pkg::PADDR_W-1] == nnl_pkg::REG_DIST_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && hit_limit)
        begin
            limit_next = pwdata[nnl_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= nnl_pkg::DIST_LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit_limit)
        begin
            prdata = {{(nnl_pkg::PDATA_W-nnl_pkg::DIST_W){1'b0}}, limit_reg};
        end
    end

    assign pready        = 1'b1;
    assign dist_limit_sq = limit_reg;

endmodule

`default_nettype wire

@@ hdl/nnl_ctrl.sv @@
// Sequencer for clear, load and query items.
// Depends on nnl_pkg.
`default_nettype none

module nnl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [1:0]          action,
    output logic                     in_ready,
    input  wire nnl_pkg::dp_stat_t   stat,
    output nnl_pkg::dp_cmd_t         cmd
);

    nnl_pkg::state_t state_reg;
    nnl_pkg::state_t state_next;
    logic            accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nnl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            nnl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    case (action)
                        nnl_pkg::ACT_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        nnl_pkg::ACT_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        nnl_pkg::ACT_QUERY:
                        begin
                            cmd.start_query = 1'b1;
                            state_next = stat.empty ? nnl_pkg::ST_FINISH : nnl_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            nnl_pkg::ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = nnl_pkg::ST_DRAIN;
                end
            end
            nnl_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = nnl_pkg::ST_FINISH;
                end
            end
            nnl_pkg::ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = nnl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nnl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/nnl_dp.sv @@
// Datapath: point memory, distance pipeline, running minimum, output register.
// Depends on nnl_pkg.
`default_nettype none

module nnl_dp #(
    parameter int unsigned MAX_POINTS = nnl_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire nnl_pkg::dp_cmd_t                      cmd,
    output nnl_pkg::dp_stat_t                          stat,
    input  wire logic signed [nnl_pkg::COORD_W-1:0]    coord_x,
    input  wire logic signed [nnl_pkg::COORD_W-1:0]    coord_y,
    input  wire logic signed [nnl_pkg::COORD_W-1:0]    sample_value,
    input  wire logic        [nnl_pkg::DIST_W-1:0]     dist_limit_sq,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic                                       found,
    output logic             [nnl_pkg::INDEX_W-1:0]    nearest_index,
    output logic signed      [nnl_pkg::COORD_W-1:0]    nearest_value
);

    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned CRD = nnl_pkg::COORD_W;
    localparam int unsigned MW = 3 * CRD;
    localparam int unsigned SW = nnl_pkg::SQ_W;
    localparam int unsigned DW = nnl_pkg::DIST_W;

    // x | y | value per entry
    logic [MW-1:0] mem [MAX_POINTS];

    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  scan_reg, scan_next;
    logic [CRD-1:0] qx_reg, qy_reg;

    // stage 0: memory read
    logic           v0_reg;
    logic [CW-1:0]  idx0_reg;
    logic [MW-1:0]  rd_reg;

    // stage 1: squares
    logic           v1_reg;
    logic [CW-1:0]  idx1_reg;
    logic [SW-1:0]  sqx_reg, sqy_reg;
    logic [CRD-1:0] val1_reg;

    // running minimum
    logic [DW-1:0]  best_reg;
    logic [CW-1:0]  best_idx_reg;
    logic [CRD-1:0] best_val_reg;
    logic           hit_reg;

    // output register
    logic           out_valid_reg;
    logic           found_reg;
    logic [CW-1:0]  out_idx_reg;
    logic [CRD-1:0] out_val_reg;

    logic                 can_load;
    logic signed [CRD:0]  dx, dy;
    logic signed [2*CRD+1:0] px, py;
    logic [DW-1:0]        dist_sum;
    logic                 closer;

    assign can_load = (count_reg < CW'(MAX_POINTS));

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.load && can_load)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.start_query)
        begin
            scan_next = '0;
        end
        else if (cmd.issue)
        begin
            scan_next = scan_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && can_load)
        begin
            mem[count_reg[AW-1:0]] <= {coord_x, coord_y, sample_value};
        end
        rd_reg <= mem[scan_reg[AW-1:0]];
    end

    // Q8.8 differences span 17 bits; their squares fit in 32
    assign dx = {qx_reg[CRD-1], qx_reg} - {rd_reg[MW-1], rd_reg[MW-1 -: CRD]};
    assign dy = {qy_reg[CRD-1], qy_reg} - {rd_reg[2*CRD-1], rd_reg[2*CRD-1 -: CRD]};
    assign px = dx * dx;
    assign py = dy * dy;

    assign dist_sum = {{(DW-SW){1'b0}}, sqx_reg} + {{(DW-SW){1'b0}}, sqy_reg};
    assign closer   = v1_reg && (dist_sum < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_reg      <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            scan_reg  <= scan_next;
            v0_reg    <= cmd.issue;
            v1_reg    <= v0_reg;
            if (cmd.start_query)
            begin
                hit_reg <= 1'b0;
            end
            else if (closer)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            qx_reg       <= coord_x;
            qy_reg       <= coord_y;
            best_reg     <= dist_limit_sq;
            best_idx_reg <= count_reg;
        end
        else if (closer)
        begin
            best_reg     <= dist_sum;
            best_idx_reg <= idx1_reg;
            best_val_reg <= val1_reg;
        end
        idx0_reg <= scan_reg;
        idx1_reg <= idx0_reg;
        sqx_reg  <= px[SW-1:0];
        sqy_reg  <= py[SW-1:0];
        val1_reg <= rd_reg[CRD-1:0];
        if (cmd.load_out)
        begin
            found_reg   <= hit_reg;
            out_idx_reg <= best_idx_reg;
            out_val_reg <= hit_reg ? best_val_reg : '0;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.scan_last = (scan_reg == count_reg - CW'(1));
    assign stat.pipe_busy = v0_reg || v1_reg;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign nearest_index = nnl_pkg::INDEX_W'(out_idx_reg);
    assign nearest_value = out_val_reg;

endmodule

`default_nettype wire

@@ hdl/nearest_neighbor_2d_lookup_unit.sv @@
// Clear and load items finish when accepted; a query over N stored points
// reads one point from memory per cycle, then passes them through a two-stage
// square/compare pipeline, and an empty table skips the scan.
// One item is in work at a time; the result sits in an output register.
// Reset (rst_n, async low) empties the table and sets the limit to 100000.0.
`default_nettype none

module nearest_neighbor_2d_lookup_unit #(
    parameter int unsigned MAX_POINTS = nnl_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [nnl_pkg::PADDR_W-1:0]   paddr,
    input  wire logic        [nnl_pkg::PDATA_W-1:0]   pwdata,
    output logic             [nnl_pkg::PDATA_W-1:0]   prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic        [1:0]                    action,
    input  wire logic signed [nnl_pkg::COORD_W-1:0]   coord_x,
    input  wire logic signed [nnl_pkg::COORD_W-1:0]   coord_y,
    input  wire logic signed [nnl_pkg::COORD_W-1:0]   sample_value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      found,
    output logic             [nnl_pkg::INDEX_W-1:0]   nearest_index,
    output logic signed      [nnl_pkg::COORD_W-1:0]   nearest_value
);

    logic [nnl_pkg::DIST_W-1:0] dist_limit_sq;
    nnl_pkg::dp_cmd_t           cmd;
    nnl_pkg::dp_stat_t          stat;

    nnl_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .dist_limit_sq (dist_limit_sq)
    );

    nnl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nnl_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .sample_value  (sample_value),
        .dist_limit_sq (dist_limit_sq),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .found         (found),
        .nearest_index (nearest_index),
        .nearest_value (nearest_value)
    );

endmodule

`default_nettype wire
